// ===== rtl/core/jdhm_pkg.sv =====
// Package with the request types and constants of the joystick dead-zone and hat mapper.
`default_nettype none

package jdhm_pkg;

    // Converter resolution in bits.
    localparam int ADC_BITS = 12;
    // Width of a converter sample and of the range registers.
    localparam int ADC_W = ADC_BITS;
    // Width of the dead band register.
    localparam int BAND_W = 11;
    // Width of the hat threshold register.
    localparam int THR_W = 15;
    // Width of a scaled axis value.
    localparam int AXIS_W = 16;
    // Width of the hat code.
    localparam int HAT_W = 4;
    // Signed width that holds a zone edge, an offset or a span.
    localparam int EDGE_W = ADC_W + 2;
    // Quotient width of the scaling division.
    localparam int QUO_W = 15;
    // Full scale of an axis.
    localparam logic [QUO_W-1:0] AXIS_FULL = 15'd32767;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_ADC_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HAT_THR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_H   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_V   = 3'd7;

    // Hat codes, named by compass direction.
    localparam logic [HAT_W-1:0] DIR_CENTER = 4'd0;
    localparam logic [HAT_W-1:0] DIR_N      = 4'd1;
    localparam logic [HAT_W-1:0] DIR_NE     = 4'd2;
    localparam logic [HAT_W-1:0] DIR_E      = 4'd3;
    localparam logic [HAT_W-1:0] DIR_SE     = 4'd4;
    localparam logic [HAT_W-1:0] DIR_S      = 4'd5;
    localparam logic [HAT_W-1:0] DIR_SW     = 4'd6;
    localparam logic [HAT_W-1:0] DIR_W      = 4'd7;
    localparam logic [HAT_W-1:0] DIR_NW     = 4'd8;

    // Divider pipeline shape: quotient bits resolved per stage and stage count.
    localparam int DIV_BITS_PER_STG = 3;
    localparam int DIV_STAGES       = QUO_W / DIV_BITS_PER_STG;

    // How an axis result is formed once the side and span are known.
    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_FULL,
        KIND_DIV
    } t_axis_kind;

    typedef struct packed {
        logic [ADC_W-1:0] raw_x;
        logic [ADC_W-1:0] raw_y;
    } t_in_req;

    typedef struct packed {
        logic signed [AXIS_W-1:0] axis_x;
        logic signed [AXIS_W-1:0] axis_y;
        logic [HAT_W-1:0]         hat;
    } t_out_req;

endpackage

`default_nettype wire

// ===== rtl/core/joystick_deadzone_hat_mapper_core.sv =====
// Top level of the joystick dead-zone mapper with 8-way hat decision.
`default_nettype none

// Each request carries one pair of converter samples and yields exactly one result
// request: both axes scaled to -32767..32767 with a dead zone of +-dead_band around
// each axis's own center, and an 8-way hat code taken from the axes after optional
// inversion and compared against the hat threshold register. The block is a
// ten-stage pipeline that accepts one request every cycle unless a stall at the
// output side has backed up to the input, and results leave from the output register.
// The depth is set by the scaling division, a 15-bit restoring
// divider that resolves three quotient bits in each of five stages; two stages ahead
// of it find the active side, offset and span, one forms the dividend, and two after
// it finish the axis value and the hat code. Stalls propagate backward through the
// stages, so empty stages still fill while a finished result waits in the output
// register. Configuration registers are written through a plain write port and must
// only change while the pipeline is empty. The converter resolution is a fixed
// twelve bits taken from the package.
module joystick_deadzone_hat_mapper_core
    import jdhm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input request channel.
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_req               i_in_req,
    // Result request channel.
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_req                   o_out_req,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Pipeline positions: 0 zone edges, 1 side select, 2 dividend, 3..7 divider,
    // 8 axis value, 9 output register with the hat code.
    localparam int NSTG    = 10;
    localparam int POS_DIV = 2;
    localparam int POS_AX  = POS_DIV + DIV_STAGES + 1;

    // Configuration registers.
    logic [ADC_W-1:0]  r_adc_min;
    logic [ADC_W-1:0]  r_adc_max;
    logic [ADC_W-1:0]  r_center_x;
    logic [ADC_W-1:0]  r_center_y;
    logic [BAND_W-1:0] r_dead_band;
    logic [THR_W-1:0]  r_hat_thr;
    logic              r_invert_h;
    logic              r_invert_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_min   <= '0;
            r_adc_max   <= '1;
            r_center_x  <= 12'd2048;
            r_center_y  <= 12'd2048;
            r_dead_band <= 11'd64;
            r_hat_thr   <= 15'd16384;
            r_invert_h  <= 1'b0;
            r_invert_v  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ADC_MIN:   r_adc_min   <= i_cfg_data[ADC_W-1:0];
                CFG_ADC_MAX:   r_adc_max   <= i_cfg_data[ADC_W-1:0];
                CFG_CENTER_X:  r_center_x  <= i_cfg_data[ADC_W-1:0];
                CFG_CENTER_Y:  r_center_y  <= i_cfg_data[ADC_W-1:0];
                CFG_DEAD_BAND: r_dead_band <= i_cfg_data[BAND_W-1:0];
                CFG_HAT_THR:   r_hat_thr   <= i_cfg_data[THR_W-1:0];
                CFG_INVERT_H:  r_invert_h  <= i_cfg_data[0];
                CFG_INVERT_V:  r_invert_v  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline flow control. A stage advances when it is empty or when the stage
    // after it advances; the output register advances when the consumer takes it.
    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   adv;

    always_comb begin
        adv[NSTG] = !i_out_stall;
        for (int k = NSTG - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_in_stall  = !adv[0];
    assign o_out_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Scaled axis values at the stage ahead of the output register.
    logic signed [AXIS_W-1:0] r_axis [2];

    for (genvar g = 0; g < 2; g++) begin : g_axis
        logic [ADC_W-1:0]        raw_in;
        logic [ADC_W-1:0]        center_m;

        // Position 0: sample and the two zone edges.
        logic [ADC_W-1:0]        r_raw;
        logic signed [EDGE_W-1:0] r_edge_lo;
        logic signed [EDGE_W-1:0] r_edge_hi;

        // Position 1: active side, offset into it and its span.
        logic signed [EDGE_W-1:0] raw_s;
        logic signed [EDGE_W-1:0] lo_s;
        logic signed [EDGE_W-1:0] hi_s;
        logic                     below;
        logic                     above;
        logic                     r_below;
        logic                     r_above;
        logic signed [EDGE_W-1:0] r_off;
        logic signed [EDGE_W-1:0] r_span;

        // Position 2 and the divider stages: index 0 is the dividend stage.
        t_axis_kind               kind_c;
        logic [ADC_W-1:0]         off_u;
        logic [ADC_W+QUO_W-1:0]   num_c;
        t_axis_kind               r_kind [DIV_STAGES+1];
        logic                     r_low  [DIV_STAGES+1];
        logic [ADC_W-1:0]         r_rem  [DIV_STAGES+1];
        logic [QUO_W-1:0]         r_nlo  [DIV_STAGES+1];
        logic [ADC_W-1:0]         r_den  [DIV_STAGES+1];
        logic [QUO_W-1:0]         r_quo  [DIV_STAGES+1];

        // Axis value from the final quotient.
        logic signed [AXIS_W-1:0] n_axis;

        assign raw_in   = (g == 0) ? i_in_req.raw_x : i_in_req.raw_y;
        assign center_m = (g == 0) ? r_center_x : r_center_y;

        always_ff @(posedge i_clk) begin
            if (adv[0]) begin
                r_raw     <= raw_in;
                r_edge_lo <= $signed({2'b00, center_m}) - $signed({3'b000, r_dead_band});
                r_edge_hi <= $signed({2'b00, center_m}) + $signed({3'b000, r_dead_band});
            end
        end

        assign raw_s = $signed({2'b00, r_raw});
        assign lo_s  = $signed({2'b00, r_adc_min});
        assign hi_s  = $signed({2'b00, r_adc_max});
        assign below = raw_s < r_edge_lo;
        assign above = raw_s > r_edge_hi;

        always_ff @(posedge i_clk) begin
            if (adv[1]) begin
                r_below <= below;
                r_above <= above;
                if (below) begin
                    r_off  <= raw_s - lo_s;
                    r_span <= r_edge_lo - lo_s;
                end else begin
                    r_off  <= raw_s - r_edge_hi;
                    r_span <= hi_s - r_edge_hi;
                end
            end
        end

        // A side with a span that is zero or reversed always lands on zero after
        // clamping. Below center a negative offset clamps to the low end; above
        // center an offset that reaches the span clamps to the high end. What is
        // left is an offset in 0..span-1, so the quotient fits in 15 bits.
        always_comb begin
            if (!(r_below || r_above) || (r_span <= 0)) begin
                kind_c = KIND_ZERO;
            end else if (r_below) begin
                kind_c = (r_off < 0) ? KIND_FULL : KIND_DIV;
            end else begin
                kind_c = (r_off >= r_span) ? KIND_FULL : KIND_DIV;
            end
        end

        assign off_u = r_off[ADC_W-1:0];
        // The offset times 32767 is the offset shifted by 15 less the offset.
        assign num_c = {off_u, {QUO_W{1'b0}}} - {{QUO_W{1'b0}}, off_u};

        always_ff @(posedge i_clk) begin
            if (adv[POS_DIV]) begin
                r_kind[0] <= kind_c;
                r_low[0]  <= r_below;
                r_rem[0]  <= num_c[ADC_W+QUO_W-1:QUO_W];
                r_nlo[0]  <= num_c[QUO_W-1:0];
                r_den[0]  <= r_span[ADC_W-1:0];
                r_quo[0]  <= '0;
            end
        end

        for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
            logic [ADC_W-1:0] rem_c;
            logic [QUO_W-1:0] nlo_c;
            logic [QUO_W-1:0] quo_c;
            logic [ADC_W:0]   trial;

            // Restoring division, DIV_BITS_PER_STG quotient bits per stage.
            always_comb begin
                rem_c = r_rem[s-1];
                nlo_c = r_nlo[s-1];
                quo_c = r_quo[s-1];
                trial = '0;
                for (int j = 0; j < DIV_BITS_PER_STG; j++) begin
                    trial = {rem_c, nlo_c[QUO_W-1]};
                    nlo_c = {nlo_c[QUO_W-2:0], 1'b0};
                    if (trial >= {1'b0, r_den[s-1]}) begin
                        rem_c = ADC_W'(trial - {1'b0, r_den[s-1]});
                        quo_c = {quo_c[QUO_W-2:0], 1'b1};
                    end else begin
                        rem_c = trial[ADC_W-1:0];
                        quo_c = {quo_c[QUO_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (adv[POS_DIV+s]) begin
                    r_kind[s] <= r_kind[s-1];
                    r_low[s]  <= r_low[s-1];
                    r_rem[s]  <= rem_c;
                    r_nlo[s]  <= nlo_c;
                    r_den[s]  <= r_den[s-1];
                    r_quo[s]  <= quo_c;
                end
            end
        end

        // Below center the quotient is shifted down by full scale.
        always_comb begin
            case (r_kind[DIV_STAGES])
                KIND_FULL: begin
                    n_axis = r_low[DIV_STAGES] ? -$signed({1'b0, AXIS_FULL})
                                               : $signed({1'b0, AXIS_FULL});
                end
                KIND_DIV: begin
                    n_axis = r_low[DIV_STAGES]
                        ? $signed({1'b0, r_quo[DIV_STAGES]}) - $signed({1'b0, AXIS_FULL})
                        : $signed({1'b0, r_quo[DIV_STAGES]});
                end
                default: begin
                    n_axis = '0;
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (adv[POS_AX]) begin
                r_axis[g] <= n_axis;
            end
        end
    end

    // Hat decision on the axes after optional inversion. A value equal to the
    // threshold in magnitude does not count as a direction.
    logic signed [AXIS_W:0] hx;
    logic signed [AXIS_W:0] hy;
    logic signed [AXIS_W:0] thr_s;
    logic                   up;
    logic                   down;
    logic                   right;
    logic                   left;
    logic [HAT_W-1:0]       hat_c;
    t_out_req               r_out;

    assign hx    = r_invert_h ? -$signed({r_axis[0][AXIS_W-1], r_axis[0]})
                              : $signed({r_axis[0][AXIS_W-1], r_axis[0]});
    assign hy    = r_invert_v ? -$signed({r_axis[1][AXIS_W-1], r_axis[1]})
                              : $signed({r_axis[1][AXIS_W-1], r_axis[1]});
    assign thr_s = $signed({2'b00, r_hat_thr});
    assign up    = hy > thr_s;
    assign down  = hy < -thr_s;
    assign right = hx > thr_s;
    assign left  = hx < -thr_s;

    always_comb begin
        if (up && right) begin
            hat_c = DIR_NE;
        end else if (up && left) begin
            hat_c = DIR_NW;
        end else if (down && right) begin
            hat_c = DIR_SE;
        end else if (down && left) begin
            hat_c = DIR_SW;
        end else if (up) begin
            hat_c = DIR_N;
        end else if (down) begin
            hat_c = DIR_S;
        end else if (right) begin
            hat_c = DIR_E;
        end else if (left) begin
            hat_c = DIR_W;
        end else begin
            hat_c = DIR_CENTER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[NSTG-1]) begin
            r_out.axis_x <= r_axis[0];
            r_out.axis_y <= r_axis[1];
            r_out.hat    <= hat_c;
        end
    end

    assign o_out_req = r_out;

endmodule

`default_nettype wire
